// ===== rtl/mwf_pkg.sv =====
// mwf_pkg: shared codes and control types for the mutex with FIFO handoff.
// No dependencies; imported by mwf_queue and mutex_with_fifo_handoff.
package mwf_pkg;

    // request codes
    localparam logic [1:0] REQ_LOCK    = 2'd0;
    localparam logic [1:0] REQ_TRYLOCK = 2'd1;
    localparam logic [1:0] REQ_UNLOCK  = 2'd2;
    localparam logic [1:0] REQ_DESTROY = 2'd3;

    // result status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_QUEUED    = 3'd1;
    localparam logic [2:0] ST_BUSY      = 3'd2;
    localparam logic [2:0] ST_NOT_OWNER = 3'd3;
    localparam logic [2:0] ST_QFULL     = 3'd4;
    localparam logic [2:0] ST_OVERFLOW  = 3'd5;

    // mode register values
    localparam logic MODE_PLAIN    = 1'b0;
    localparam logic MODE_COUNTING = 1'b1;

    typedef struct packed {
        logic push;
        logic pop;
        logic clear;
    } t_q_ctrl;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_stat;

endpackage

// ===== rtl/mwf_queue.sv =====
// mwf_queue: wait queue of thread ids in a synchronous memory with pointers.
// Depends on mwf_pkg (t_q_ctrl, t_q_stat).
module mwf_queue #(
    parameter int THREAD_ID_BITS = 8,
    parameter int QUEUE_DEPTH    = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  mwf_pkg::t_q_ctrl          i_ctrl,
    input  logic [THREAD_ID_BITS-1:0] i_push_id,
    input  logic                      i_rd_en,
    output logic [THREAD_ID_BITS-1:0] o_rd_data,
    output mwf_pkg::t_q_stat          o_stat
);
    import mwf_pkg::*;

    localparam int PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

    logic [THREAD_ID_BITS-1:0] r_mem [QUEUE_DEPTH];
    logic [THREAD_ID_BITS-1:0] r_rd_data;
    logic [PTR_W-1:0]          r_head, r_tail;
    logic [PTR_W-1:0]          n_head, n_tail;
    logic [FILL_W-1:0]         r_fill;

    assign n_head = (r_head == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_head + 1'b1;
    assign n_tail = (r_tail == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_tail + 1'b1;

    assign o_stat.empty = (r_fill == '0);
    assign o_stat.full  = (r_fill == FILL_W'(QUEUE_DEPTH));
    assign o_rd_data    = r_rd_data;

    // memory: one write port, one registered read port at the head
    always_ff @(posedge i_clk) begin
        if (i_ctrl.push) begin
            r_mem[r_tail] <= i_push_id;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[r_head];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_fill <= '0;
        end else if (i_ctrl.clear) begin
            r_head <= '0;
            r_tail <= '0;
            r_fill <= '0;
        end else if (i_ctrl.push) begin
            r_tail <= n_tail;
            r_fill <= r_fill + 1'b1;
        end else if (i_ctrl.pop) begin
            r_head <= n_head;
            r_fill <= r_fill - 1'b1;
        end
    end

`ifndef SYNTHESIS
    a_push_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.push |-> !o_stat.full)
        else $error("push into full wait queue");
    a_pop_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.pop |-> !o_stat.empty)
        else $error("pop from empty wait queue");
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(QUEUE_DEPTH))
        else $error("wait queue fill beyond depth");
    a_single_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones({i_ctrl.push, i_ctrl.pop, i_ctrl.clear}) <= 1)
        else $error("more than one queue operation at once");
`endif

endmodule

// ===== rtl/mutex_with_fifo_handoff.sv =====
// mutex_with_fifo_handoff: top level of the hardware lock with a FIFO wait queue.
// Depends on mwf_pkg and mwf_queue.
//
// Hardware recursive mutex. Each input transaction is one request (lock,
// trylock, unlock, destroy) from one thread and yields exactly one result
// transaction. On acceptance a request reads the head of the wait-queue
// memory into its registered read port; in S_EXEC it decides, updates
// owner, count and queue, and loads the result register. The next request
// is taken as soon as the block is back in its idle state, even while the
// previous result still waits in the result register; it then waits in
// S_EXEC until that register is free. A new request is not taken before
// the previous one is decided. The mode register (plain or counting) is
// written through its own channel, always ready, and applies to every
// request decided after the write. Reset leaves the lock free and the
// queue empty; queue memory contents are undefined but never used unless written.
module mutex_with_fifo_handoff #(
    parameter int THREAD_ID_BITS = 8,
    parameter int QUEUE_DEPTH    = 16,
    parameter int COUNT_BITS     = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // configuration channel
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic                      i_mutex_type,
    // request channel
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [1:0]                i_req_type,
    input  logic [THREAD_ID_BITS-1:0] i_thread_id,
    // result channel
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [2:0]                o_status,
    output logic                      o_handoff_valid,
    output logic [THREAD_ID_BITS-1:0] o_handoff_thread,
    output logic                      o_owner_valid,
    output logic [THREAD_ID_BITS-1:0] o_owner_thread
);
    import mwf_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state r_state;

    // mode and lock state
    logic                      r_mode;
    logic                      r_held, n_held;
    logic [THREAD_ID_BITS-1:0] r_owner, n_owner;
    logic [COUNT_BITS-1:0]     r_count, n_count;

    // captured request
    logic [1:0]                r_req;
    logic [THREAD_ID_BITS-1:0] r_tid;

    // result register
    logic                      r_out_valid;
    logic [2:0]                r_status, n_status;
    logic                      r_hv, n_hv;
    logic [THREAD_ID_BITS-1:0] r_ht, n_ht;
    logic                      r_ov;
    logic [THREAD_ID_BITS-1:0] r_ot;

    // queue interface
    t_q_ctrl                   q_ctrl;
    t_q_stat                   q_stat;
    logic [THREAD_ID_BITS-1:0] q_rd_data;

    logic w_in_acc, w_cfg_acc, w_exec;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_acc   = i_cfg_valid;
    assign o_in_ready  = (r_state == S_IDLE);
    assign w_in_acc    = i_in_valid && o_in_ready;
    // decide only when the result register can take the answer
    assign w_exec      = (r_state == S_EXEC) && (!r_out_valid || i_out_ready);

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_status;
    assign o_handoff_valid  = r_hv;
    assign o_handoff_thread = r_ht;
    assign o_owner_valid    = r_ov;
    assign o_owner_thread   = r_ot;

    mwf_queue #(
        .THREAD_ID_BITS (THREAD_ID_BITS),
        .QUEUE_DEPTH    (QUEUE_DEPTH)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (q_ctrl),
        .i_push_id (r_tid),
        .i_rd_en   (w_in_acc),
        .o_rd_data (q_rd_data),
        .o_stat    (q_stat)
    );

    // request decision; head entry was read in the accepting cycle
    always_comb begin
        n_held   = r_held;
        n_owner  = r_owner;
        n_count  = r_count;
        n_status = ST_OK;
        n_hv     = 1'b0;
        n_ht     = '0;
        q_ctrl   = '0;
        unique case (r_req)
            REQ_LOCK: begin
                if (!r_held) begin
                    n_held  = 1'b1;
                    n_owner = r_tid;
                    n_count = '0;
                end else if (r_owner == r_tid) begin
                    // plain relock by owner is a no-op
                    if (r_mode == MODE_COUNTING) begin
                        if (&r_count) begin
                            n_status = ST_OVERFLOW;
                        end else begin
                            n_count = r_count + 1'b1;
                        end
                    end
                end else if (q_stat.full) begin
                    n_status = ST_QFULL;
                end else begin
                    q_ctrl.push = 1'b1;
                    n_status    = ST_QUEUED;
                end
            end
            REQ_TRYLOCK: begin
                if (!r_held) begin
                    n_held  = 1'b1;
                    n_owner = r_tid;
                    n_count = '0;
                end else if (r_owner == r_tid && r_mode == MODE_COUNTING) begin
                    if (&r_count) begin
                        n_status = ST_OVERFLOW;
                    end else begin
                        n_count = r_count + 1'b1;
                    end
                end else begin
                    n_status = ST_BUSY;
                end
            end
            REQ_UNLOCK: begin
                if (!r_held || r_owner != r_tid) begin
                    n_status = ST_NOT_OWNER;
                end else if (r_mode == MODE_COUNTING && r_count != '0) begin
                    n_count = r_count - 1'b1;
                end else if (!q_stat.empty) begin
                    // hand over to the head waiter
                    q_ctrl.pop = 1'b1;
                    n_owner    = q_rd_data;
                    n_count    = '0;
                    n_hv       = 1'b1;
                    n_ht       = q_rd_data;
                end else begin
                    n_held  = 1'b0;
                    n_owner = '0;
                    n_count = '0;
                end
            end
            REQ_DESTROY: begin
                n_held       = 1'b0;
                n_owner      = '0;
                n_count      = '0;
                q_ctrl.clear = 1'b1;
            end
        endcase
        if (!w_exec) begin
            q_ctrl = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mode      <= MODE_PLAIN;
            r_held      <= 1'b0;
            r_owner     <= '0;
            r_count     <= '0;
            r_req       <= REQ_LOCK;
            r_tid       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_cfg_acc) begin
                r_mode <= i_mutex_type;
            end
            // a new answer replaces the one taken at this edge
            if (w_exec) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_req   <= i_req_type;
                        r_tid   <= i_thread_id;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (w_exec) begin
                        r_held      <= n_held;
                        r_owner     <= n_owner;
                        r_count     <= n_count;
                        r_status    <= n_status;
                        r_hv        <= n_hv;
                        r_ht        <= n_ht;
                        r_ov        <= n_held;
                        r_ot        <= n_held ? n_owner : '0;
                        r_state     <= S_IDLE;
                    end
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_handoff_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_handoff_valid) |->
            (o_owner_valid && o_owner_thread == o_handoff_thread))
        else $error("handoff result without matching owner");
    a_free_owner_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_owner_valid) |-> (o_owner_thread == '0))
        else $error("free lock reports an owner");
    a_queued_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_QUEUED) |-> o_owner_valid)
        else $error("request queued on a free lock");
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state == S_EXEC))
        else $error("accepted request not executed");
    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC && r_out_valid && !i_out_ready) |=> r_state == S_EXEC)
        else $error("result register overwritten while stalled");
`endif

endmodule

// ===== tb/mutex_with_fifo_handoff_tb.sv =====
// Self-checking testbench for mutex_with_fifo_handoff: directed and random requests
// checked against a cycle-free predictor of the lock. Depends on mwf_pkg and the RTL.
`timescale 1ns / 1ps

module mutex_with_fifo_handoff_tb;
    import mwf_pkg::*;

    localparam int THREAD_ID_BITS = 8;
    localparam int QUEUE_DEPTH    = 16;
    localparam int COUNT_BITS     = 16;

    localparam int HALF_PERIOD    = 6;
    localparam int RESET_CYCLES   = 7;
    localparam int WATCHDOG_LIMIT = 3000;   // cycles with no transaction on any channel
    localparam int LONG_HOLD      = 150;    // receiver back-pressure stretch
    localparam int SETTLE_CYCLES  = 8;      // quiet time after the last result
    localparam int RANDOM_PHASES  = 6;
    localparam int PHASE_ITEMS    = 300;
    localparam int SHOWN_MAX      = 10;

    // one request transaction
    typedef struct packed {
        logic [1:0]                req;
        logic [THREAD_ID_BITS-1:0] tid;
    } t_lock_req;

    // one result transaction, fields in port order
    typedef struct packed {
        logic [2:0]                status;
        logic                      handoff_valid;
        logic [THREAD_ID_BITS-1:0] handoff_thread;
        logic                      owner_valid;
        logic [THREAD_ID_BITS-1:0] owner_thread;
    } t_lock_result;

    // architectural state of the lock
    typedef struct packed {
        logic                                         held;
        logic [THREAD_ID_BITS-1:0]                    owner;
        logic [COUNT_BITS-1:0]                        count;
        logic [QUEUE_DEPTH-1:0][THREAD_ID_BITS-1:0]   waiters;
        logic [$clog2(QUEUE_DEPTH)-1:0]               head;
        logic [$clog2(QUEUE_DEPTH)-1:0]               tail;
        logic [$clog2(QUEUE_DEPTH):0]                 fill;
    } t_lock_state;

    // ------------------------------------------------------------------
    // Clock, reset and DUT-facing signals; the driven ones known from time zero
    // ------------------------------------------------------------------
    logic                      clk       = 1'b0;
    logic                      rst_n     = 1'b0;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_mode  = MODE_PLAIN;
    logic                      in_valid  = 1'b0;
    logic [1:0]                req_type  = REQ_LOCK;
    logic [THREAD_ID_BITS-1:0] thread_id = '0;
    logic                      out_ready = 1'b0;

    logic                      cfg_ready;
    logic                      in_ready;
    logic                      out_valid;
    logic [2:0]                status;
    logic                      handoff_valid;
    logic [THREAD_ID_BITS-1:0] handoff_thread;
    logic                      owner_valid;
    logic [THREAD_ID_BITS-1:0] owner_thread;

    always #(HALF_PERIOD) clk = ~clk;

    mutex_with_fifo_handoff #(
        .THREAD_ID_BITS (THREAD_ID_BITS),
        .QUEUE_DEPTH    (QUEUE_DEPTH),
        .COUNT_BITS     (COUNT_BITS)
    ) i_dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_valid      (cfg_valid),
        .o_cfg_ready      (cfg_ready),
        .i_mutex_type     (cfg_mode),
        .i_in_valid       (in_valid),
        .o_in_ready       (in_ready),
        .i_req_type       (req_type),
        .i_thread_id      (thread_id),
        .o_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .o_status         (status),
        .o_handoff_valid  (handoff_valid),
        .o_handoff_thread (handoff_thread),
        .o_owner_valid    (owner_valid),
        .o_owner_thread   (owner_thread)
    );

    // ------------------------------------------------------------------
    // Bookkeeping shared between the processes
    // ------------------------------------------------------------------
    t_lock_req    pending_reqs[$];       // requests waiting for the driver
    t_lock_result expected_results[$];   // predicted results, oldest first

    t_lock_state  tracked_lock  = '0;    // predictor state, advanced on acceptance
    logic         tracked_mode  = MODE_PLAIN;
    t_lock_state  planned_lock  = '0;    // generator's view, advanced when queued
    logic         planned_mode  = MODE_PLAIN;
    logic [THREAD_ID_BITS-1:0] thread_pool[4];

    bit in_fire      = 1'b0;   // request transaction taken at the last rising edge
    bit calm         = 1'b0;   // no random idling on either side
    int holds_asked  = 0;      // long receiver holds requested ...
    int holds_done   = 0;      // ... and started
    int send_gap     = 0;
    int recv_gap     = 0;

    int issued_count   = 0;
    int accepted_count = 0;
    int result_count   = 0;
    int cfg_writes     = 0;
    int handoff_count  = 0;
    int error_count    = 0;
    int shown_count    = 0;
    int quiet_cycles   = 0;
    int status_tally[8];

    t_lock_result want;
    t_lock_result got;
    t_lock_result step_res;

    // ------------------------------------------------------------------
    // Predictor: next lock state and the result of one request
    // ------------------------------------------------------------------
    function automatic t_lock_state lock_next(input t_lock_state s, input logic mode,
                                              input t_lock_req rq, output t_lock_result r);
        t_lock_state n;
        n = s;
        r = '0;
        r.status = ST_OK;
        case (rq.req)
            REQ_LOCK: begin
                if (!n.held) begin
                    n.held  = 1'b1;
                    n.owner = rq.tid;
                    n.count = '0;
                end else if (n.owner == rq.tid) begin
                    // plain relock by the owner is a silent no-op
                    if (mode == MODE_COUNTING) begin
                        if (n.count == '1)
                            r.status = ST_OVERFLOW;
                        else
                            n.count = n.count + 1'b1;
                    end
                end else if (n.fill == QUEUE_DEPTH) begin
                    r.status = ST_QFULL;
                end else begin
                    n.waiters[n.tail] = rq.tid;
                    n.tail   = n.tail + 1'b1;
                    n.fill   = n.fill + 1'b1;
                    r.status = ST_QUEUED;
                end
            end
            REQ_TRYLOCK: begin
                if (!n.held) begin
                    n.held  = 1'b1;
                    n.owner = rq.tid;
                    n.count = '0;
                end else if (n.owner == rq.tid && mode == MODE_COUNTING) begin
                    if (n.count == '1)
                        r.status = ST_OVERFLOW;
                    else
                        n.count = n.count + 1'b1;
                end else begin
                    r.status = ST_BUSY;
                end
            end
            REQ_UNLOCK: begin
                if (!n.held || n.owner != rq.tid) begin
                    r.status = ST_NOT_OWNER;
                end else if (mode == MODE_COUNTING && n.count != '0) begin
                    n.count = n.count - 1'b1;
                end else if (n.fill != '0) begin
                    // hand the lock straight to the oldest waiter
                    r.handoff_valid  = 1'b1;
                    r.handoff_thread = n.waiters[n.head];
                    n.owner = n.waiters[n.head];
                    n.count = '0;
                    n.head  = n.head + 1'b1;
                    n.fill  = n.fill - 1'b1;
                end else begin
                    n.held  = 1'b0;
                    n.owner = '0;
                    n.count = '0;
                end
            end
            default: begin
                n = '0;   // destroy, from any thread
            end
        endcase
        r.owner_valid  = n.held;
        r.owner_thread = n.held ? n.owner : '0;
        return n;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_item(input logic [1:0] req, input logic [THREAD_ID_BITS-1:0] tid);
        t_lock_req    rq;
        t_lock_result unused;
        rq.req = req;
        rq.tid = tid;
        planned_lock = lock_next(planned_lock, planned_mode, rq, unused);
        pending_reqs.push_back(rq);
        issued_count++;
    endtask

    function automatic logic [THREAD_ID_BITS-1:0] pool_thread();
        return thread_pool[$urandom_range(0, 3)];
    endfunction

    // Mostly well-formed traffic around the current owner; unlock_pct steers
    // between a filling and a draining wait queue.
    function automatic t_lock_req pick_request(input int unlock_pct);
        t_lock_req rq;
        int        roll;
        roll   = $urandom_range(0, 99);
        rq.tid = pool_thread();
        if (roll < 4) begin
            rq.req = 2'($urandom_range(0, 3));
            rq.tid = THREAD_ID_BITS'($urandom_range(0, (1 << THREAD_ID_BITS) - 1));
        end else if (roll < 6) begin
            rq.req = REQ_DESTROY;
        end else if (!planned_lock.held) begin
            rq.req = ($urandom_range(0, 3) == 0) ? REQ_TRYLOCK : REQ_LOCK;
        end else begin
            roll = $urandom_range(0, 99);
            if (roll < unlock_pct) begin
                rq.req = REQ_UNLOCK;
                rq.tid = planned_lock.owner;
            end else if (roll < unlock_pct + 10) begin
                rq.req = ($urandom_range(0, 1) == 0) ? REQ_LOCK : REQ_TRYLOCK;
                rq.tid = planned_lock.owner;
            end else if (roll < unlock_pct + 17) begin
                rq.req = REQ_UNLOCK;
            end else if (roll < unlock_pct + 25) begin
                rq.req = REQ_TRYLOCK;
            end else begin
                rq.req = REQ_LOCK;
            end
        end
        return rq;
    endfunction

    // mode register write; only called with nothing in flight
    task automatic write_mode(input logic m);
        int target;
        target = cfg_writes + 1;
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_mode  <= m;
        do @(negedge clk); while (cfg_writes != target);
        cfg_valid    <= 1'b0;
        planned_mode  = m;
    endtask

    task automatic wait_drained();
        do @(negedge clk);
        while (accepted_count != issued_count || expected_results.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // Request driver: one transaction per pending entry, random idle bursts
    // ------------------------------------------------------------------
    always @(negedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (in_valid && !in_fire) begin
            // offer stays up, payload unchanged, until taken
        end else if (send_gap > 0) begin
            send_gap--;
            in_valid <= 1'b0;
        end else if (pending_reqs.size() == 0) begin
            in_valid <= 1'b0;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
            send_gap = $urandom_range(1, 9) - 1;
            in_valid <= 1'b0;
        end else begin
            req_type  <= pending_reqs[0].req;
            thread_id <= pending_reqs[0].tid;
            in_valid  <= 1'b1;
            void'(pending_reqs.pop_front());
        end
    end

    // ------------------------------------------------------------------
    // Result receiver: random stalls plus the occasional long hold-off
    // ------------------------------------------------------------------
    always @(negedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else if (recv_gap > 0) begin
            recv_gap--;
            out_ready <= 1'b0;
        end else if (holds_done != holds_asked) begin
            holds_done++;
            recv_gap = LONG_HOLD - 1;
            out_ready <= 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
            recv_gap = $urandom_range(1, 9) - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks results, runs the predictor on accepted requests,
    // tracks mode writes and guards against a hang
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        in_fire = 1'b0;
        if (rst_n) begin
            quiet_cycles++;

            // results first: a request taken at this edge cannot answer yet
            if (out_valid && out_ready) begin
                quiet_cycles = 0;
                result_count++;
                got = {status, handoff_valid, handoff_thread, owner_valid, owner_thread};
                if (expected_results.size() == 0) begin
                    error_count++;
                    if (shown_count < SHOWN_MAX)
                        $display("%0t: result with nothing outstanding: ",
                                 "status %0d owner %0d/%0d",
                                 $realtime, got.status, got.owner_valid,
                                 got.owner_thread);
                    shown_count++;
                end else begin
                    want = expected_results.pop_front();
                    status_tally[want.status]++;
                    if (want.handoff_valid)
                        handoff_count++;
                    if (got.status !== want.status
                            || got.handoff_valid !== want.handoff_valid
                            || got.handoff_thread !== want.handoff_thread
                            || got.owner_valid !== want.owner_valid
                            || got.owner_thread !== want.owner_thread) begin
                        error_count++;
                        if (shown_count < SHOWN_MAX)
                            $display("%0t: result %0d mismatch: ",
                                     "exp st %0d ho %0d/%0d own %0d/%0d, ",
                                     "got st %0d ho %0d/%0d own %0d/%0d",
                                     $realtime, result_count,
                                     want.status, want.handoff_valid, want.handoff_thread,
                                     want.owner_valid, want.owner_thread,
                                     got.status, got.handoff_valid, got.handoff_thread,
                                     got.owner_valid, got.owner_thread);
                        shown_count++;
                    end
                end
            end

            if (in_valid && in_ready) begin
                quiet_cycles = 0;
                in_fire      = 1'b1;
                accepted_count++;
                tracked_lock = lock_next(tracked_lock, tracked_mode,
                                         '{req: req_type, tid: thread_id}, step_res);
                expected_results.push_back(step_res);
            end

            // mode change applies from the next request on
            if (cfg_valid && cfg_ready) begin
                quiet_cycles = 0;
                tracked_mode = cfg_mode;
                cfg_writes++;
            end

            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no transaction for %0d cycles, %0d results outstanding",
                         $realtime, quiet_cycles, expected_results.size());
                $display("mutex_with_fifo_handoff_tb: errors");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        int        p;
        int        k;
        int        unlock_pct;
        t_lock_req rq;

        foreach (status_tally[i])
            status_tally[i] = 0;

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        // Plain mode: free-lock unlock, trylock grant, silent relock, busy answers,
        // a thread queued twice, non-owner unlock, two handoffs, release, destroy.
        write_mode(MODE_PLAIN);
        @(posedge clk);
        push_item(REQ_UNLOCK,  8'd5);
        push_item(REQ_TRYLOCK, 8'd0);
        push_item(REQ_LOCK,    8'd0);
        push_item(REQ_TRYLOCK, 8'd0);
        push_item(REQ_TRYLOCK, 8'd7);
        push_item(REQ_LOCK,    8'd255);
        push_item(REQ_LOCK,    8'd255);
        push_item(REQ_UNLOCK,  8'd255);
        push_item(REQ_UNLOCK,  8'd0);
        push_item(REQ_UNLOCK,  8'd255);
        push_item(REQ_UNLOCK,  8'd255);
        push_item(REQ_LOCK,    8'd3);
        push_item(REQ_DESTROY, 8'd9);
        wait_drained();

        // Counting mode: relocks via lock and trylock, unwind, handoff once the
        // count is back at zero, destroy with a waiter present.
        write_mode(MODE_COUNTING);
        @(posedge clk);
        push_item(REQ_LOCK,    8'd4);
        push_item(REQ_LOCK,    8'd4);
        push_item(REQ_TRYLOCK, 8'd4);
        push_item(REQ_UNLOCK,  8'd4);
        push_item(REQ_UNLOCK,  8'd9);
        push_item(REQ_LOCK,    8'd6);
        push_item(REQ_UNLOCK,  8'd4);
        push_item(REQ_UNLOCK,  8'd4);
        push_item(REQ_LOCK,    8'd200);
        push_item(REQ_DESTROY, 8'd200);
        push_item(REQ_LOCK,    8'd8);
        push_item(REQ_LOCK,    8'd8);
        wait_drained();

        // Mode flips with the lock held: plain unlock ignores the count
        write_mode(MODE_PLAIN);
        @(posedge clk);
        push_item(REQ_UNLOCK,  8'd8);
        push_item(REQ_LOCK,    8'd8);
        wait_drained();
        write_mode(MODE_COUNTING);
        @(posedge clk);
        push_item(REQ_UNLOCK,  8'd8);
        wait_drained();

        // Random phases: alternating mode, small thread pools so that the
        // same threads contend, and a bias that fills or drains the queue.
        // State carries over between phases, so modes change with the lock held.
        for (p = 0; p < RANDOM_PHASES; p++) begin
            write_mode(p[0] ? MODE_COUNTING : MODE_PLAIN);
            unlock_pct = (p % 3 == 0) ? 15 : ((p % 3 == 1) ? 45 : 28);
            foreach (thread_pool[i])
                thread_pool[i] = THREAD_ID_BITS'($urandom_range(0,
                                                 (1 << THREAD_ID_BITS) - 1));
            @(posedge clk);
            if (p == RANDOM_PHASES - 1)
                calm = 1'b1;
            for (k = 0; k < PHASE_ITEMS; k++) begin
                rq = pick_request(unlock_pct);
                push_item(rq.req, rq.tid);
            end
            // receiver backs off while requests keep coming, so the block fills
            if (p == 0 || p == 3)
                holds_asked++;
            wait_drained();
        end

        $display("covered %0d requests and %0d results over %0d mode writes, %0d handoffs",
                 accepted_count, result_count, cfg_writes, handoff_count);
        $display("answers: ok %0d, queued %0d, busy %0d, ",
                 "not owner %0d, queue full %0d, overflow %0d",
                 status_tally[ST_OK], status_tally[ST_QUEUED], status_tally[ST_BUSY],
                 status_tally[ST_NOT_OWNER], status_tally[ST_QFULL],
                 status_tally[ST_OVERFLOW]);
        if (error_count == 0 && expected_results.size() == 0)
            $display("mutex_with_fifo_handoff_tb: clean");
        else
            $display("mutex_with_fifo_handoff_tb: errors");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/mwf_pkg.sv
rtl/mwf_queue.sv
rtl/mutex_with_fifo_handoff.sv
tb/mutex_with_fifo_handoff_tb.sv
